// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers included by the deque top level, double_ended_queue.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W      = 32;
    localparam int OCC_W       = 5;
    localparam int DEPTH_DFLT  = 16;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    // per-row command: shift toward the tail, shift toward the head,
    // or load the push word at the cell that sits at the current count
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } row_ctl_t;

endpackage

// ===== design/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of a row: holds a word, takes it from either neighbor or the push word.
// ----------------------------------------------------------------------------
module dq_cell (
    input  logic                         clk,
    input  dq_pkg::row_ctl_t             ctl,
    input  logic [dq_pkg::WORD_W-1:0]    lower_word,
    input  logic [dq_pkg::WORD_W-1:0]    upper_word,
    input  logic [dq_pkg::WORD_W-1:0]    push_word,
    output logic [dq_pkg::WORD_W-1:0]    word
);

    logic [dq_pkg::WORD_W-1:0] word_reg;
    logic [dq_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        priority if (ctl.shift_up)
        begin
            word_next = lower_word;
        end
        else if (ctl.shift_down)
        begin
            word_next = upper_word;
        end
        else if (ctl.load)
        begin
            word_next = push_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== design/dq_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_row
// Row of DEPTH cells with its head at cell 0.
// ----------------------------------------------------------------------------
module dq_row #(
    parameter int DEPTH = dq_pkg::DEPTH_DFLT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  dq_pkg::row_ctl_t             ctl,
    input  logic [CW-1:0]                count,
    input  logic [dq_pkg::WORD_W-1:0]    push_word,
    output logic [dq_pkg::WORD_W-1:0]    head_word
);

    logic [dq_pkg::WORD_W-1:0] words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dq_pkg::row_ctl_t          cell_ctl;
        logic [dq_pkg::WORD_W-1:0] lower_word;
        logic [dq_pkg::WORD_W-1:0] upper_word;

        assign cell_ctl.shift_up   = ctl.shift_up;
        assign cell_ctl.shift_down = ctl.shift_down;
        assign cell_ctl.load       = ctl.load && (count == CW'(i));

        if (i == 0)
        begin : g_first
            assign lower_word = push_word;
        end
        else
        begin : g_inner
            assign lower_word = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_word = words[i];
        end
        else
        begin : g_body
            assign upper_word = words[i+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .lower_word (lower_word),
            .upper_word (upper_word),
            .push_word  (push_word),
            .word       (words[i])
        );
    end

    assign head_word = words[0];

endmodule

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit words with push and pop at both ends.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while in_stall is low, and its result
// is registered. The output register plus one skid entry take one more item
// while the consumer stalls; after that in_stall stays high until the output
// drains, and the skid entry moves into the output register before the next
// item is taken. Words live in two rows of DEPTH cells holding the same
// contents in opposite order: the front row has the front word at its head
// cell, the back row the back word. A push at one end shifts that end's row by
// one cell and writes the word into the other row at the cell given by the
// count; a pop reads the head cell of its end's row and shifts that row. Every
// cell of a row moves in parallel within the cycle, and at most one other cell
// is written, which sets the one-item-per-cycle rate.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DFLT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic signed [dq_pkg::WORD_W-1:0]    push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dq_pkg::WORD_W-1:0]    pop_value,
    output logic                                was_empty,
    output logic                                overflow,
    output logic [dq_pkg::OCC_W-1:0]            occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [dq_pkg::WORD_W-1:0] value;
        logic                      empty;
        logic                      ovf;
        logic [dq_pkg::OCC_W-1:0]  occ;
    } result_t;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    result_t                   out_reg;
    result_t                   out_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   skid_reg;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;

    dq_pkg::op_t               op;
    dq_pkg::row_ctl_t          front_ctl;
    dq_pkg::row_ctl_t          back_ctl;
    logic [dq_pkg::WORD_W-1:0] front_head;
    logic [dq_pkg::WORD_W-1:0] back_head;
    logic                      accept;
    logic                      out_fire;
    logic                      is_full;
    logic                      is_empty;
    logic                      push_grow;
    logic                      pop_on_empty;
    result_t                   res;

    assign op       = dq_pkg::op_t'(func);
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign push_grow    = accept && !func[1] && !is_full;
    assign pop_on_empty = accept && func[1] && is_empty;

    always_comb
    begin
        front_ctl  = '0;
        back_ctl   = '0;
        count_next = count_reg;
        res.value  = dq_pkg::EMPTY_WORD;
        res.empty  = 1'b0;
        res.ovf    = 1'b0;
        unique case (op)
            dq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    res.ovf = 1'b1;
                end
                else
                begin
                    front_ctl.shift_up = accept;
                    back_ctl.load      = accept;
                    count_next         = count_reg + CW'(1);
                end
            end
            dq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    res.ovf = 1'b1;
                end
                else
                begin
                    back_ctl.shift_up = accept;
                    front_ctl.load    = accept;
                    count_next        = count_reg + CW'(1);
                end
            end
            dq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    res.empty = 1'b1;
                end
                else
                begin
                    res.value            = front_head;
                    front_ctl.shift_down = accept;
                    count_next           = count_reg - CW'(1);
                end
            end
            dq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    res.empty = 1'b1;
                end
                else
                begin
                    res.value           = back_head;
                    back_ctl.shift_down = accept;
                    count_next          = count_reg - CW'(1);
                end
            end
            default:
            begin
                res.value = dq_pkg::EMPTY_WORD;
            end
        endcase
        res.occ = dq_pkg::OCC_W'(count_next);
    end

    dq_row #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front_row (
        .clk       (clk),
        .ctl       (front_ctl),
        .count     (count_reg),
        .push_word (push_value),
        .head_word (front_head)
    );

    dq_row #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_back_row (
        .clk       (clk),
        .ctl       (back_ctl),
        .count     (count_reg),
        .push_word (push_value),
        .head_word (back_head)
    );

    // output stage plus skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg && out_fire)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else if (accept && (!out_valid_reg || out_fire))
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept && out_valid_reg && !out_fire)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = out_reg.value;
    assign was_empty = out_reg.empty;
    assign overflow  = out_reg.ovf;
    assign occupancy = out_reg.occ;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH), "count beyond depth")
    `ASSERT_IMPLIES(a_skid_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid alone")
    `ASSERT_NEXT(a_push, clk, rst_n, push_grow, count_reg == $past(count_reg) + CW'(1), "push lost")
    `ASSERT_NEXT(a_empty_pop, clk, rst_n, pop_on_empty, $stable(count_reg), "empty pop moved count")

endmodule
